// File: rtl/tht_pkg.sv
// ----------------------------------------------------------------------------
// tht_pkg: shared types and constants for the typed handle table
// Command and status codes, table geometry and entry word layout.
// ----------------------------------------------------------------------------
`default_nettype none

package tht_pkg;

	localparam int TABLE_ENTRIES = 1024;
	localparam int TYPE_BITS     = 4;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = IDX_W + 1;
	localparam int PAYLOAD_W     = 32;
	localparam int ENTRY_W       = 1 + TYPE_BITS + PAYLOAD_W;

	localparam int CMD_W    = 2;
	localparam int SLOT_W   = 10;
	localparam int TAG_W    = 4;
	localparam int STATUS_W = 3;
	localparam int IN_W     = 48;
	localparam int OUT_W    = 48;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD    = 2'd0,
		CMD_GET    = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_BAD_INDEX = 3'd1,
		ST_MISMATCH  = 3'd2,
		ST_FULL      = 3'd3,
		ST_ZERO      = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_POP
	} state_t;

	typedef struct packed {
		logic                 valid;
		logic [TYPE_BITS-1:0] tag;
		logic [PAYLOAD_W-1:0] payload;
	} entry_t;

endpackage

`default_nettype wire

// File: rtl/tht_ram.sv
// ----------------------------------------------------------------------------
// tht_ram: generic single-port-write, single-port-read RAM
// One write port and one read port with a registered read and read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module tht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/typed_handle_table_core.sv
// ----------------------------------------------------------------------------
// typed_handle_table_core: handle table with typed entries and a free stack
// Add, get and remove commands over a table of entries held in RAM.
// ----------------------------------------------------------------------------
// Commands enter on the s_axis stream, one transaction per command, and each
// command gives exactly one result transaction on the m_axis stream.
// A get, a remove, a failed add and an add that takes a fresh index pass
// from acceptance through S_LOOK to the output register; an add that pops a
// freed index also passes through S_POP, since the popped index needs a
// second read of the entry RAM. One command is in flight at a time: a new
// command is taken only once the last one finishes; the RAM reads are registered.
// The result sits in an output register; while the receiver stalls the
// register holds its transaction and a finished command waits for it, and
// no new command is accepted until the pending one enters the register.
// Reset empties the free stack and restarts fresh indices at one; entries
// at or above the fresh index read as not in use, so no clearing pass is
// needed and commands are accepted right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module typed_handle_table_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_axis_tvalid,
	output logic                           s_axis_tready,
	// cmd[1:0], slot_index[11:2], elem_type[15:12], payload[47:16]
	input  wire logic [tht_pkg::IN_W-1:0]  s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  wire logic                      m_axis_tready,
	// status[2:0], given_index[12:3], read_value[44:13], zeros[47:45]
	output logic      [tht_pkg::OUT_W-1:0] m_axis_tdata
);

	import tht_pkg::*;

	state_t state_q, state_d;

	cmd_t                 cmd_q;
	logic [IDX_W-1:0]     idx_q;
	logic [TYPE_BITS-1:0] tag_q;
	logic [PAYLOAD_W-1:0] val_q;
	logic [IDX_W-1:0]     slot_q, slot_d;
	logic [CNT_W-1:0]     depth_q, depth_d;
	logic [CNT_W-1:0]     fresh_q, fresh_d;

	logic                 out_valid_q;
	status_t              out_status_q;
	logic [SLOT_W-1:0]    out_given_q;
	logic [PAYLOAD_W-1:0] out_value_q;

	logic                 ent_we, ent_re;
	logic [IDX_W-1:0]     ent_waddr, ent_raddr;
	entry_t               ent_wdata, ent_rdata;
	logic [ENTRY_W-1:0]   ent_rword;
	logic                 stk_we, stk_re;
	logic [IDX_W-1:0]     stk_waddr, stk_raddr;
	logic [IDX_W-1:0]     stk_rdata;

	logic                 out_free, finish;
	logic                 want_ent_we, want_stk_we;
	status_t              res_status;
	logic [IDX_W-1:0]     res_given;
	logic [PAYLOAD_W-1:0] res_value;
	logic [CNT_W-1:0]     want_depth, want_fresh;
	logic                 live;

	tht_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.re    (ent_re),
		.raddr (ent_raddr),
		.rdata (ent_rword)
	);

	assign ent_rdata = entry_t'(ent_rword);

	tht_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_ENTRIES)) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (idx_q),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	assign out_free = !out_valid_q || m_axis_tready;
	assign live     = (idx_q != '0) && ({1'b0, idx_q} < fresh_q) && ent_rdata.valid;

	always_comb begin
		state_d     = state_q;
		s_axis_tready = 1'b0;
		ent_re      = 1'b0;
		ent_raddr   = s_axis_tdata[IDX_W+1:2];
		stk_re      = 1'b0;
		stk_raddr   = depth_q[IDX_W-1:0] - IDX_W'(1);
		stk_waddr   = depth_q[IDX_W-1:0];
		ent_waddr   = idx_q;
		ent_wdata   = '0;
		want_ent_we = 1'b0;
		want_stk_we = 1'b0;
		finish      = 1'b0;
		res_status  = ST_BAD_INDEX;
		res_given   = '0;
		res_value   = '0;
		want_depth  = depth_q;
		want_fresh  = fresh_q;
		slot_d      = slot_q;
		depth_d     = depth_q;
		fresh_d     = fresh_q;

		case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					ent_re  = 1'b1;
					stk_re  = 1'b1;
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				case (cmd_q)
					CMD_ADD: begin
						if (val_q == '0) begin
							res_status = ST_ZERO;
							finish     = 1'b1;
						end else if (depth_q != '0) begin
							slot_d    = stk_rdata;
							ent_re    = 1'b1;
							ent_raddr = stk_rdata;
							depth_d   = depth_q - CNT_W'(1);
							state_d   = S_POP;
						end else if (fresh_q < CNT_W'(TABLE_ENTRIES)) begin
							res_status  = ST_OK;
							res_given   = fresh_q[IDX_W-1:0];
							ent_waddr   = fresh_q[IDX_W-1:0];
							ent_wdata   = '{valid: 1'b1, tag: tag_q, payload: val_q};
							want_ent_we = 1'b1;
							want_fresh  = fresh_q + CNT_W'(1);
							finish      = 1'b1;
						end else begin
							res_status = ST_FULL;
							finish     = 1'b1;
						end
					end
					CMD_GET: begin
						finish = 1'b1;
						if (live) begin
							if (ent_rdata.tag == tag_q) begin
								res_status = ST_OK;
								res_value  = ent_rdata.payload;
							end else begin
								res_status = ST_MISMATCH;
							end
						end
					end
					CMD_REMOVE: begin
						finish = 1'b1;
						if (live) begin
							res_status  = ST_OK;
							want_ent_we = 1'b1;
							if (depth_q < CNT_W'(TABLE_ENTRIES)) begin
								want_stk_we = 1'b1;
								want_depth  = depth_q + CNT_W'(1);
							end
						end
					end
					default: begin
						finish = 1'b1;
					end
				endcase
			end
			S_POP: begin
				finish    = 1'b1;
				ent_waddr = slot_q;
				if (!ent_rdata.valid) begin
					res_status  = ST_OK;
					res_given   = slot_q;
					ent_wdata   = '{valid: 1'b1, tag: tag_q, payload: val_q};
					want_ent_we = 1'b1;
				end else begin
					res_status = ST_FULL;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		ent_we = want_ent_we && finish && out_free;
		stk_we = want_stk_we && finish && out_free;
		if (finish && out_free) begin
			depth_d = want_depth;
			fresh_d = want_fresh;
			state_d = S_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			depth_q     <= '0;
			fresh_q     <= CNT_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			depth_q <= depth_d;
			fresh_q <= fresh_d;
			if (finish && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		slot_q <= slot_d;
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_q <= cmd_t'(s_axis_tdata[1:0]);
			idx_q <= s_axis_tdata[IDX_W+1:2];
			tag_q <= s_axis_tdata[12 +: TYPE_BITS];
			val_q <= s_axis_tdata[47:16];
		end
		if (finish && out_free) begin
			out_status_q <= res_status;
			out_given_q  <= SLOT_W'(res_given);
			out_value_q  <= res_value;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_value_q, out_given_q, out_status_q};

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: regression for typed_handle_table_core
// A directed script covers reset state, zero payload, tag mismatch, reserved
// and out-of-range indices, the unknown command and LIFO reuse of freed
// slots. A random mix of add, get, remove and unknown commands follows, with
// one sweep that frees live slots. Each result is compared with the script or
// a behavioral copy of the table, under bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tht_pkg::*;

	localparam int IDLE_LIMIT = 5000;
	localparam int LONG_HOLD  = 300;

	typedef struct packed {
		logic [PAYLOAD_W-1:0] payload;
		logic [TAG_W-1:0]     tag;
		logic [SLOT_W-1:0]    slot;
		cmd_t                 cmd;
	} cmd_word_t;

	typedef struct packed {
		logic [2:0]           pad;
		logic [PAYLOAD_W-1:0] read_value;
		logic [SLOT_W-1:0]    given_index;
		status_t              status;
	} reply_word_t;

	typedef struct packed {
		cmd_t                 cmd;
		logic [SLOT_W-1:0]    slot;
		logic [TAG_W-1:0]     tag;
		logic [PAYLOAD_W-1:0] payload;
		bit                   fixed;
		status_t              status;
		logic [SLOT_W-1:0]    given_index;
		logic [PAYLOAD_W-1:0] read_value;
	} script_row_t;

	localparam int SCRIPT_LEN = 22;
	localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
		'{CMD_GET,    10'd1,    4'h0, 32'h0,        1'b1, ST_BAD_INDEX, 10'd0, 32'h0},
		'{CMD_REMOVE, 10'd0,    4'h0, 32'h0,        1'b1, ST_BAD_INDEX, 10'd0, 32'h0},
		'{CMD_ADD,    10'd0,    4'h3, 32'h0,        1'b1, ST_ZERO,      10'd0, 32'h0},
		'{CMD_ADD,    10'h3ff,  4'hf, 32'hffffffff, 1'b1, ST_OK,        10'd1, 32'h0},
		'{CMD_ADD,    10'd0,    4'h0, 32'h1,        1'b1, ST_OK,        10'd2, 32'h0},
		'{CMD_GET,    10'd1,    4'hf, 32'h0,        1'b1, ST_OK,        10'd0, 32'hffffffff},
		'{CMD_GET,    10'd1,    4'h0, 32'h0,        1'b1, ST_MISMATCH,  10'd0, 32'h0},
		'{CMD_GET,    10'd0,    4'h0, 32'h0,        1'b1, ST_BAD_INDEX, 10'd0, 32'h0},
		'{CMD_GET,    10'h3ff,  4'hf, 32'h0,        1'b1, ST_BAD_INDEX, 10'd0, 32'h0},
		'{CMD_NONE,   10'd1,    4'hf, 32'hdeadbeef, 1'b1, ST_BAD_INDEX, 10'd0, 32'h0},
		'{CMD_REMOVE, 10'd1,    4'h6, 32'h5a5a5a5a, 1'b1, ST_OK,        10'd0, 32'h0},
		'{CMD_GET,    10'd1,    4'hf, 32'h0,        1'b1, ST_BAD_INDEX, 10'd0, 32'h0},
		'{CMD_REMOVE, 10'd1,    4'hf, 32'h0,        1'b1, ST_BAD_INDEX, 10'd0, 32'h0},
		'{CMD_ADD,    10'h2aa,  4'h5, 32'h12345678, 1'b1, ST_OK,        10'd1, 32'h0},
		'{CMD_ADD,    10'h155,  4'ha, 32'h80000000, 1'b1, ST_OK,        10'd3, 32'h0},
		'{CMD_REMOVE, 10'd2,    4'h0, 32'h0,        1'b1, ST_OK,        10'd0, 32'h0},
		'{CMD_REMOVE, 10'd3,    4'h0, 32'h0,        1'b1, ST_OK,        10'd0, 32'h0},
		'{CMD_ADD,    10'd0,    4'h9, 32'h0badf00d, 1'b1, ST_OK,        10'd3, 32'h0},
		'{CMD_ADD,    10'd0,    4'h7, 32'h00010000, 1'b1, ST_OK,        10'd2, 32'h0},
		'{CMD_GET,    10'd3,    4'h9, 32'h0,        1'b0, ST_OK,        10'd0, 32'h0},
		'{CMD_GET,    10'd2,    4'h6, 32'h0,        1'b0, ST_OK,        10'd0, 32'h0},
		'{CMD_GET,    10'd4,    4'h0, 32'hffffffff, 1'b0, ST_OK,        10'd0, 32'h0}
	};

	logic                 clk;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [IN_W-1:0]      s_axis_tdata  = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [OUT_W-1:0]     m_axis_tdata;

	logic                 tbl_valid [TABLE_ENTRIES];
	logic [TYPE_BITS-1:0] tbl_tag   [TABLE_ENTRIES];
	logic [PAYLOAD_W-1:0] tbl_data  [TABLE_ENTRIES];
	logic [IDX_W-1:0]     freed_slots [TABLE_ENTRIES];
	logic [CNT_W-1:0]     free_cnt;
	logic [CNT_W-1:0]     next_fresh;

	reply_word_t          pending_replies [$];
	int                   mismatch_count = 0;
	int                   burst_left     = 0;
	int                   hold_requests  = 0;

	typed_handle_table_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_table();
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			tbl_valid[i]   = 1'b0;
			tbl_tag[i]     = '0;
			tbl_data[i]    = '0;
			freed_slots[i] = '0;
		end
		free_cnt   = '0;
		next_fresh = CNT_W'(1);
	endfunction

	function automatic bit slot_live(logic [SLOT_W-1:0] idx);
		return idx != 0 && idx < next_fresh && tbl_valid[idx];
	endfunction

	function automatic reply_word_t execute_cmd(cmd_word_t c);
		reply_word_t      r;
		logic [IDX_W-1:0] slot;
		bit               have;
		r        = '0;
		r.status = ST_BAD_INDEX;
		slot     = '0;
		have     = 1'b0;
		case (c.cmd)
			CMD_ADD: begin
				if (c.payload == 0) begin
					r.status = ST_ZERO;
				end else begin
					if (free_cnt > 0) begin
						free_cnt = free_cnt - CNT_W'(1);
						slot     = freed_slots[free_cnt];
						have     = !tbl_valid[slot];
					end else if (next_fresh < TABLE_ENTRIES) begin
						slot       = next_fresh[IDX_W-1:0];
						next_fresh = next_fresh + CNT_W'(1);
						have       = 1'b1;
					end
					if (have) begin
						tbl_valid[slot] = 1'b1;
						tbl_tag[slot]   = c.tag;
						tbl_data[slot]  = c.payload;
						r.status        = ST_OK;
						r.given_index   = slot;
					end else begin
						r.status = ST_FULL;
					end
				end
			end
			CMD_GET: begin
				if (slot_live(c.slot)) begin
					if (tbl_tag[c.slot] == c.tag) begin
						r.status     = ST_OK;
						r.read_value = tbl_data[c.slot];
					end else begin
						r.status = ST_MISMATCH;
					end
				end
			end
			CMD_REMOVE: begin
				if (slot_live(c.slot)) begin
					tbl_valid[c.slot] = 1'b0;
					tbl_tag[c.slot]   = '0;
					tbl_data[c.slot]  = '0;
					if (free_cnt < TABLE_ENTRIES) begin
						freed_slots[free_cnt] = c.slot;
						free_cnt              = free_cnt + CNT_W'(1);
					end
					r.status = ST_OK;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [SLOT_W-1:0] pick_live_slot();
		logic [SLOT_W-1:0] idx;
		idx = SLOT_W'($urandom_range(0, TABLE_ENTRIES - 1));
		if (next_fresh > 1) begin
			for (int t = 0; t < 12; t++) begin
				idx = SLOT_W'($urandom_range(1, next_fresh - 1));
				if (tbl_valid[idx])
					break;
			end
		end
		return idx;
	endfunction

	function automatic cmd_word_t random_cmd();
		cmd_word_t c;
		int        r;
		c.cmd     = CMD_NONE;
		c.slot    = SLOT_W'($urandom_range(0, TABLE_ENTRIES - 1));
		c.tag     = TAG_W'($urandom_range(0, 15));
		c.payload = $urandom;
		r         = $urandom_range(0, 99);
		if (r < 38) begin
			c.cmd = CMD_ADD;
			if ($urandom_range(0, 19) == 0)
				c.payload = '0;
		end else if (r < 68) begin
			c.cmd = CMD_GET;
			if ($urandom_range(0, 6) != 0) begin
				c.slot = pick_live_slot();
				c.tag  = tbl_tag[c.slot];
				if ($urandom_range(0, 4) == 0)
					c.tag = c.tag ^ 4'($urandom_range(1, 15));
			end
		end else if (r < 94) begin
			c.cmd = CMD_REMOVE;
			if ($urandom_range(0, 6) != 0)
				c.slot = pick_live_slot();
		end
		return c;
	endfunction

	// offer one transaction, record its expected reply, then apply the burst gap
	task automatic send_cmd(cmd_word_t c, bit fixed = 1'b0, reply_word_t fixed_reply = '0);
		reply_word_t predicted;
		int          gap;
		s_axis_tdata  <= c;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predicted = execute_cmd(c);
		pending_replies.push_back(fixed ? fixed_reply : predicted);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(0, 5);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 24);
		end
	endtask

	task automatic drain_replies();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_replies.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		cmd_word_t   c;
		reply_word_t fixed_reply;
		clear_table();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < SCRIPT_LEN; i++) begin
			c                       = '0;
			c.cmd                   = SCRIPT[i].cmd;
			c.slot                  = SCRIPT[i].slot;
			c.tag                   = SCRIPT[i].tag;
			c.payload               = SCRIPT[i].payload;
			fixed_reply             = '0;
			fixed_reply.status      = SCRIPT[i].status;
			fixed_reply.given_index = SCRIPT[i].given_index;
			fixed_reply.read_value  = SCRIPT[i].read_value;
			send_cmd(c, SCRIPT[i].fixed, fixed_reply);
		end

		repeat (250) send_cmd(random_cmd());
		drain_replies();

		// probe the top index, then free a part of the live slots
		c         = random_cmd();
		c.cmd     = CMD_ADD;
		c.payload = '0;
		send_cmd(c);
		c         = '0;
		c.cmd     = CMD_GET;
		c.slot    = SLOT_W'(TABLE_ENTRIES - 1);
		c.tag     = tbl_tag[TABLE_ENTRIES - 1];
		send_cmd(c);
		c.cmd = CMD_REMOVE;
		send_cmd(c);
		repeat (20) begin
			c     = random_cmd();
			c.cmd = CMD_REMOVE;
			c.slot = pick_live_slot();
			send_cmd(c);
		end

		hold_requests <= hold_requests + 1;
		repeat (250) send_cmd(random_cmd());
		drain_replies();

		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && pending_replies.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	int          rx_cycle  = 0;
	int          hold_left = 0;
	int          hold_seen = 0;
	reply_word_t got;
	reply_word_t want;

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			got = reply_word_t'(m_axis_tdata);
			if (pending_replies.size() == 0) begin
				$error("unexpected result transaction %h", m_axis_tdata);
				mismatch_count++;
			end else begin
				want = pending_replies.pop_front();
				if (got.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, got.status);
					mismatch_count++;
				end
				if (got.given_index !== want.given_index) begin
					$error("given_index: expected %0d, actual %0d",
						want.given_index, got.given_index);
					mismatch_count++;
				end
				if (got.read_value !== want.read_value) begin
					$error("read_value: expected %h, actual %h",
						want.read_value, got.read_value);
					mismatch_count++;
				end
			end
		end

		rx_cycle++;
		if (hold_seen != hold_requests) begin
			hold_seen++;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			case ((rx_cycle >> 7) % 4)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 1) == 0);
				2: m_axis_tready <= ($urandom_range(0, 7) != 0);
				default: m_axis_tready <= (rx_cycle % 4 == 0);
			endcase
		end
	end

	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

endmodule
